// ===== hw/rtl/assert_macros.svh =====
// Concurrent check helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication, checked outside reset only.
`define ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/lrt_pkg.sv =====
package lrt_pkg;

	localparam int KEY_W       = 32;
	localparam int CMD_W       = 3;
	localparam int CNT_W       = 5;
	localparam int STAT_W      = 2;
	localparam int ENT_W       = 5;
	localparam int MAX_RESULTS = 16;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COLLECT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SETBUSY = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

	typedef enum logic [2:0] {
		C_HOLD,
		C_CMP,
		C_INS,
		C_TOUCH,
		C_SETBUSY,
		C_POPFRONT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     busy;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC,
		ST_SCAN,
		ST_EMIT
	} st_t;

endpackage

// ===== hw/rtl/lrt_cell.sv =====
module lrt_cell #(
	parameter int KW    = 32,
	parameter int OCC_W = 5,
	parameter int IDX   = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lrt_pkg::cell_ctl_t ctl,
	input  logic [KW-1:0]     key,
	input  logic [OCC_W-1:0]  occ,
	input  logic [KW-1:0]     nb_key,
	input  logic              nb_busy,
	input  logic              rm_in,
	output logic              rm_out,
	output logic [KW-1:0]     key_q,
	output logic              busy_q,
	output logic              hit_q
);
	import lrt_pkg::*;

	localparam logic [OCC_W-1:0] ID = OCC_W'(IDX);

	logic valid;
	logic eq;
	logic is_ins;
	logic is_tail;
	logic rm_q;

	assign valid   = ID < occ;
	assign eq      = valid && (key_q == key);
	assign is_ins  = ID == occ;
	assign is_tail = ID == (occ - 1'b1);
	assign rm_out  = rm_in | eq;

	always_ff @(posedge clk) begin
		case (ctl.op)
			C_INS: begin
				if (is_ins) key_q <= key;
			end
			C_TOUCH: begin
				if (is_tail) key_q <= key;
				else if (rm_q) key_q <= nb_key;
			end
			C_POPFRONT: key_q <= nb_key;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hit_q  <= 1'b0;
			rm_q   <= 1'b0;
		end else begin
			case (ctl.op)
				C_CMP: begin
					hit_q <= eq;
					rm_q  <= valid & (rm_in | eq);
				end
				C_INS: begin
					if (is_ins) busy_q <= ctl.busy;
				end
				C_TOUCH: begin
					if (is_tail) busy_q <= ctl.busy;
					else if (rm_q) busy_q <= nb_busy;
				end
				C_SETBUSY: begin
					if (hit_q) busy_q <= ctl.busy;
				end
				C_POPFRONT: busy_q <= nb_busy;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lru_reuse_table_with_busy_skip.sv =====
// channel  dir  tdata                                        tuser                 tlast
// s_*      in   [31:0] key, [32] busy_req, [37:33] count     [2:0] cmd             -
// m_*      out  [31:0] out_key, [36:32] entries              [1:0] status, [2] hit last
// Insert, touch, lookup and set busy: accept, compare, execute, then the output register holds
// the result beat. Collect: accept, compare, then the scan of the r rounds, then one beat per
// evicted key; each round compares the oldest and newest busy flags of the cell chain.
// Reset clears occupancy and all busy flags at once; no clearing pass.
// m_tready low holds the result beat and stalls the sequencer; s_tready is high only when idle.
module lru_reuse_table_with_busy_skip #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // key, busy_req, count
	input  logic [2:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_key, entries
	output logic [2:0]  m_tuser,   // status, hit
	output logic        m_tlast
);
	import lrt_pkg::*;

	localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	st_t state_q, state_nx;

	logic [CMD_W-1:0]  cmd_q;
	logic [KW-1:0]     key_q;
	logic              busy_req_q;
	logic [CNT_W-1:0]  lim_q;
	logic [OCC_W-1:0]  occ_q;
	logic [OCC_W-1:0]  eocc_q;
	logic [OCC_W-1:0]  f_q;
	logic [OCC_W-1:0]  rem_q;
	logic [CNT_W-1:0]  n_q;

	logic              ovalid_q;
	logic [STAT_W-1:0] ostat_q;
	logic              ohit_q;
	logic [KEY_W-1:0]  okey_q;
	logic [ENT_W-1:0]  oent_q;
	logic              olast_q;

	cell_ctl_t         ctl;
	logic [KW-1:0]     keys  [CAPACITY];
	logic [CAPACITY-1:0] busy_v;
	logic [CAPACITY-1:0] hit_v;
	logic [CAPACITY:0]   rm_c;

	logic              accept;
	logic              ob_free;
	logic              beat_go;
	logic [STAT_W-1:0] b_stat;
	logic              b_hit;
	logic [KEY_W-1:0]  b_key;
	logic [ENT_W-1:0]  b_ent;
	logic              b_last;
	logic              occ_inc;
	logic              any_hit;
	logic              hit_busy;
	logic [OCC_W-1:0]  tail;
	logic [OCC_W-1:0]  bk;
	logic              scan_stop;
	logic              scan_front;
	logic              scan_back;
	logic [CNT_W-1:0]  cnt_in;

	assign rm_c[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KW-1:0] nb_key;
		logic          nb_busy;
		if (i == CAPACITY - 1) begin : g_end
			assign nb_key  = '0;
			assign nb_busy = 1'b0;
		end else begin : g_mid
			assign nb_key  = keys[i+1];
			assign nb_busy = busy_v[i+1];
		end
		lrt_cell #(
			.KW    (KW),
			.OCC_W (OCC_W),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.key     (key_q),
			.occ     (occ_q),
			.nb_key  (nb_key),
			.nb_busy (nb_busy),
			.rm_in   (rm_c[i]),
			.rm_out  (rm_c[i+1]),
			.key_q   (keys[i]),
			.busy_q  (busy_v[i]),
			.hit_q   (hit_v[i])
		);
	end

	assign accept   = s_tvalid & s_tready;
	assign ob_free  = ~ovalid_q | m_tready;
	assign any_hit  = |hit_v;
	assign hit_busy = |(hit_v & busy_v);
	assign tail     = occ_q - 1'b1;
	assign bk       = f_q + rem_q - 1'b1;
	assign cnt_in   = s_tdata[KEY_W+1 +: CNT_W];

	assign scan_stop  = (rem_q == '0) || (n_q == lim_q) ||
		(busy_v[f_q[IDX_W-1:0]] && busy_v[bk[IDX_W-1:0]]);
	assign scan_front = !scan_stop && !busy_v[f_q[IDX_W-1:0]];
	assign scan_back  = !scan_stop && busy_v[f_q[IDX_W-1:0]];

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nx = ST_CMP;
			ST_CMP:  state_nx = (cmd_q == CMD_COLLECT) ? ST_SCAN : ST_EXEC;
			ST_EXEC: if (ob_free) state_nx = ST_IDLE;
			ST_SCAN: if (scan_stop) state_nx = ST_EMIT;
			ST_EMIT: if (ob_free && (n_q <= CNT_W'(1))) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ctl      = '{op: C_HOLD, busy: 1'b0};
		beat_go  = 1'b0;
		b_stat   = STAT_OK;
		b_hit    = 1'b0;
		b_key    = '0;
		b_ent    = ENT_W'(occ_q);
		b_last   = 1'b1;
		occ_inc  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_CMP:  ctl.op = C_CMP;
			ST_EXEC: begin
				beat_go = ob_free;
				unique case (cmd_q)
					CMD_INSERT: begin
						if (any_hit) begin
							b_stat = STAT_DUP;
						end else if (occ_q == OCC_W'(CAPACITY)) begin
							b_stat = STAT_FULL;
						end else begin
							occ_inc = ob_free;
							b_ent   = ENT_W'(occ_q + 1'b1);
							if (ob_free) ctl = '{op: C_INS, busy: busy_req_q};
						end
					end
					CMD_TOUCH: begin
						if (!any_hit) b_stat = STAT_MISS;
						else if (ob_free) ctl = '{op: C_TOUCH, busy: hit_busy};
					end
					CMD_LOOKUP: begin
						b_hit = any_hit;
						b_key = KEY_W'(key_q);
					end
					CMD_SETBUSY: begin
						if (!any_hit) b_stat = STAT_MISS;
						else if (ob_free) ctl = '{op: C_SETBUSY, busy: busy_req_q};
					end
					default: ;
				endcase
			end
			ST_SCAN: ;
			ST_EMIT: begin
				beat_go = ob_free;
				b_ent   = ENT_W'(eocc_q);
				if (n_q != '0) begin
					b_hit  = 1'b1;
					b_last = n_q == CNT_W'(1);
					if (!busy_v[0]) begin
						b_key = KEY_W'(keys[0]);
						if (ob_free) ctl.op = C_POPFRONT;
					end else begin
						b_key = KEY_W'(keys[tail[IDX_W-1:0]]);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			occ_q    <= '0;
			ovalid_q <= 1'b0;
			n_q      <= '0;
			f_q      <= '0;
			rem_q    <= '0;
			eocc_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (beat_go) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			if (accept) begin
				f_q   <= '0;
				rem_q <= occ_q;
				n_q   <= '0;
			end
			if (state_q == ST_SCAN) begin
				if (scan_front) begin
					f_q   <= f_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					n_q   <= n_q + 1'b1;
				end else if (scan_back) begin
					rem_q <= rem_q - 1'b1;
					n_q   <= n_q + 1'b1;
				end else begin
					eocc_q <= occ_q - OCC_W'(n_q);
				end
			end
			if (occ_inc) occ_q <= occ_q + 1'b1;
			if (state_q == ST_EMIT && beat_go && n_q != '0) begin
				occ_q <= occ_q - 1'b1;
				n_q   <= n_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= s_tuser;
			key_q      <= s_tdata[KW-1:0];
			busy_req_q <= s_tdata[KEY_W];
			lim_q      <= (cnt_in > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : cnt_in;
		end
		if (beat_go) begin
			ostat_q <= b_stat;
			ohit_q  <= b_hit;
			okey_q  <= b_key;
			oent_q  <= b_ent;
			olast_q <= b_last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {3'b000, oent_q, okey_q};
	assign m_tuser  = {ohit_q, ostat_q};
	assign m_tlast  = olast_q;

`include "assert_macros.svh"

	`ASSERT_RST(a_occ_cap, occ_q <= OCC_W'(CAPACITY), "occupancy above capacity")
	`ASSERT_IMP(a_hit_unique, state_q == ST_EXEC, $onehot0(hit_v), "key held in two cells")
	`ASSERT_IMP(a_scan_lim, state_q == ST_SCAN, n_q <= lim_q, "collect rounds above limit")
	`ASSERT_IMP(a_emit_occ, state_q == ST_EMIT && n_q != '0, occ_q != '0,
		"evict from empty table")
	`ASSERT_IMP(a_beat_free, beat_go, !ovalid_q || m_tready, "result beat overwritten")

endmodule
